// ===== hw/rtl/pwa_pkg.sv =====
// ----------------------------------------------------------------------------
// pwa_pkg
// Shared types and register map for the perspective warp address core.
// ----------------------------------------------------------------------------
`default_nettype none

package pwa_pkg;

  localparam int unsigned RegIdxBits = 3;
  localparam int unsigned FracShift  = 14;

  localparam logic [RegIdxBits-1:0] REG_ROW_ROW    = 3'd0;
  localparam logic [RegIdxBits-1:0] REG_ROW_COL    = 3'd1;
  localparam logic [RegIdxBits-1:0] REG_ROW_OFFSET = 3'd2;
  localparam logic [RegIdxBits-1:0] REG_COL_ROW    = 3'd3;
  localparam logic [RegIdxBits-1:0] REG_COL_COL    = 3'd4;
  localparam logic [RegIdxBits-1:0] REG_COL_OFFSET = 3'd5;
  localparam logic [RegIdxBits-1:0] REG_PERSP      = 3'd6;
  localparam logic [RegIdxBits-1:0] REG_SRC_SIZE   = 3'd7;

  typedef struct packed {
    logic valid;
    logic den_zero;
    logic neg_u;
    logic neg_v;
    logic ovf_u;
    logic ovf_v;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pwa_div_cell.sv =====
// ----------------------------------------------------------------------------
// pwa_div_cell
// One restoring division step for both quotients sharing one denominator.
// ----------------------------------------------------------------------------
`default_nettype none

module pwa_div_cell #(
  parameter int unsigned CB    = 12,
  parameter int unsigned SW    = 49,
  parameter int unsigned RW    = 75,
  parameter int unsigned SHIFT = 0
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire pwa_pkg::ctrl_t       ctrl_i,
  input  wire logic [SW-1:0]        den_i,
  input  wire logic [RW-1:0]        rem_u_i,
  input  wire logic [RW-1:0]        rem_v_i,
  input  wire logic [CB-1:0]        q_u_i,
  input  wire logic [CB-1:0]        q_v_i,
  output pwa_pkg::ctrl_t            ctrl_o,
  output logic      [SW-1:0]        den_o,
  output logic      [RW-1:0]        rem_u_o,
  output logic      [RW-1:0]        rem_v_o,
  output logic      [CB-1:0]        q_u_o,
  output logic      [CB-1:0]        q_v_o
);

  logic [RW-1:0] den_sh;
  logic          ge_u, ge_v;
  logic          valid_q;
  pwa_pkg::ctrl_t ctrl_q;
  logic [SW-1:0] den_q;
  logic [RW-1:0] rem_u_q, rem_v_q, rem_u_d, rem_v_d;
  logic [CB-1:0] q_u_q, q_v_q, q_u_d, q_v_d;

  assign den_sh = {{(RW-SW){1'b0}}, den_i} << SHIFT;
  assign ge_u   = rem_u_i >= den_sh;
  assign ge_v   = rem_v_i >= den_sh;

  always_comb begin
    rem_u_d = ge_u ? rem_u_i - den_sh : rem_u_i;
    rem_v_d = ge_v ? rem_v_i - den_sh : rem_v_i;
    q_u_d   = q_u_i;
    q_v_d   = q_v_i;
    q_u_d[SHIFT] = ge_u;
    q_v_d[SHIFT] = ge_v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    ctrl_q  <= ctrl_i;
    den_q   <= den_i;
    rem_u_q <= rem_u_d;
    rem_v_q <= rem_v_d;
    q_u_q   <= q_u_d;
    q_v_q   <= q_v_d;
  end

  always_comb begin
    ctrl_o       = ctrl_q;
    ctrl_o.valid = valid_q;
  end

  assign den_o   = den_q;
  assign rem_u_o = rem_u_q;
  assign rem_v_o = rem_v_q;
  assign q_u_o   = q_u_q;
  assign q_v_o   = q_v_q;

endmodule

`default_nettype wire

// ===== hw/rtl/perspective_warp_address_core.sv =====
// ----------------------------------------------------------------------------
// perspective_warp_address_core
// Maps an output pixel through an inverse homography to a source address.
// ----------------------------------------------------------------------------
//  channel  | ports                                        | direction
//  command  | start_i, busy_o, out_row_i, out_col_i        | in
//  result   | done_o, src_row_o, src_col_o, inside_res_o   | out
//  config   | psel, penable, pwrite, paddr, pwdata, prdata | APB
//
//  One transfer per cycle; stages in order: multiply, sum, magnitude,
//  range check, one cell per quotient bit, output register. The
//  quotient cells form a pipelined chain, one bit per cell. busy_o is
//  always low; the result strobe cannot be stalled. Reset clears the
//  pipeline valids, sets the homography to identity, size to all ones.
// ----------------------------------------------------------------------------
`default_nettype none

module perspective_warp_address_core #(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  output logic                         busy_o,
  input  wire logic [COORD_BITS-1:0]   out_row_i,
  input  wire logic [COORD_BITS-1:0]   out_col_i,
  output logic                         done_o,
  output logic      [COORD_BITS-1:0]   src_row_o,
  output logic      [COORD_BITS-1:0]   src_col_o,
  output logic                         inside_res_o,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [5:0]              paddr,
  input  wire logic [63:0]             pwdata,
  output logic      [63:0]             prdata,
  output logic                         pready
);

  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned PRW = CB + 33;
  localparam int unsigned SW  = PRW + 2;
  localparam int unsigned RW  = SW + CB + pwa_pkg::FracShift;

  // configuration
  logic [31:0]     h00_q, h01_q, h02_q, h10_q, h11_q, h12_q;
  logic [63:0]     persp_q;
  logic [2*CB-1:0] size_q;
  logic            wr_en;
  logic [pwa_pkg::RegIdxBits-1:0] idx;

  assign pready = 1'b1;
  assign busy_o = 1'b0;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h00_q   <= 32'd65536;
      h01_q   <= '0;
      h02_q   <= '0;
      h10_q   <= '0;
      h11_q   <= 32'd65536;
      h12_q   <= '0;
      persp_q <= '0;
      size_q  <= '1;
    end else if (wr_en) begin
      case (idx)
        pwa_pkg::REG_ROW_ROW:    h00_q   <= pwdata[31:0];
        pwa_pkg::REG_ROW_COL:    h01_q   <= pwdata[31:0];
        pwa_pkg::REG_ROW_OFFSET: h02_q   <= pwdata[31:0];
        pwa_pkg::REG_COL_ROW:    h10_q   <= pwdata[31:0];
        pwa_pkg::REG_COL_COL:    h11_q   <= pwdata[31:0];
        pwa_pkg::REG_COL_OFFSET: h12_q   <= pwdata[31:0];
        pwa_pkg::REG_PERSP:      persp_q <= pwdata;
        pwa_pkg::REG_SRC_SIZE:   size_q  <= pwdata[2*CB-1:0];
        default:                 ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      pwa_pkg::REG_ROW_ROW:    prdata = {32'd0, h00_q};
      pwa_pkg::REG_ROW_COL:    prdata = {32'd0, h01_q};
      pwa_pkg::REG_ROW_OFFSET: prdata = {32'd0, h02_q};
      pwa_pkg::REG_COL_ROW:    prdata = {32'd0, h10_q};
      pwa_pkg::REG_COL_COL:    prdata = {32'd0, h11_q};
      pwa_pkg::REG_COL_OFFSET: prdata = {32'd0, h12_q};
      pwa_pkg::REG_PERSP:      prdata = persp_q;
      pwa_pkg::REG_SRC_SIZE:   prdata = {{(64-2*CB){1'b0}}, size_q};
      default:                 prdata = '0;
    endcase
  end

  logic [CB-1:0] src_rows, src_cols;
  assign src_rows = size_q[2*CB-1:CB];
  assign src_cols = size_q[CB-1:0];

  // stage 1: products
  logic signed [PRW-1:0] rx, cx;
  logic signed [PRW-1:0] p0_q, p1_q, p3_q, p4_q, p6_q, p7_q;
  logic                  v1_q, v2_q, v3_q, v4_q;

  assign rx = PRW'($signed({1'b0, out_row_i}));
  assign cx = PRW'($signed({1'b0, out_col_i}));

  always_ff @(posedge clk_i) begin
    p0_q <= PRW'($signed(h00_q)) * rx;
    p1_q <= PRW'($signed(h01_q)) * cx;
    p3_q <= PRW'($signed(h10_q)) * rx;
    p4_q <= PRW'($signed(h11_q)) * cx;
    p6_q <= PRW'($signed(persp_q[63:32])) * rx;
    p7_q <= PRW'($signed(persp_q[31:0])) * cx;
  end

  // stage 2: sums
  logic signed [SW-1:0] u_q, v_q, w_q;
  localparam logic signed [SW-1:0] WOne = SW'(64'd1 << 30);

  always_ff @(posedge clk_i) begin
    u_q <= SW'(p0_q) + SW'(p1_q) + SW'($signed(h02_q));
    v_q <= SW'(p3_q) + SW'(p4_q) + SW'($signed(h12_q));
    w_q <= SW'(p6_q) + SW'(p7_q) + WOne;
  end

  // stage 3: magnitudes and signs
  logic [SW-1:0] mu_q, mv_q, mw_q;
  logic          su_q, sv_q, sw_q;

  always_ff @(posedge clk_i) begin
    mu_q <= u_q[SW-1] ? SW'(-u_q) : SW'(u_q);
    mv_q <= v_q[SW-1] ? SW'(-v_q) : SW'(v_q);
    mw_q <= w_q[SW-1] ? SW'(-w_q) : SW'(w_q);
    su_q <= u_q[SW-1];
    sv_q <= v_q[SW-1];
    sw_q <= w_q[SW-1];
  end

  // stage 4: quotient range check, feeds the cell chain
  logic [RW-1:0]  nu, nv, dfull;
  pwa_pkg::ctrl_t ctrl_c [CB+1];
  logic [SW-1:0]  den_c  [CB+1];
  logic [RW-1:0]  remu_c [CB+1];
  logic [RW-1:0]  remv_c [CB+1];
  logic [CB-1:0]  qu_c   [CB+1];
  logic [CB-1:0]  qv_c   [CB+1];
  pwa_pkg::ctrl_t ctrl4_q, ctrl4;
  logic [SW-1:0]  den4_q;
  logic [RW-1:0]  remu4_q, remv4_q;

  assign nu    = {{(RW-SW-pwa_pkg::FracShift){1'b0}}, mu_q, {pwa_pkg::FracShift{1'b0}}};
  assign nv    = {{(RW-SW-pwa_pkg::FracShift){1'b0}}, mv_q, {pwa_pkg::FracShift{1'b0}}};
  assign dfull = {{(RW-SW){1'b0}}, mw_q} << CB;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= start_i & ~busy_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ctrl4_q.den_zero <= (mw_q == '0);
    ctrl4_q.neg_u    <= su_q ^ sw_q;
    ctrl4_q.neg_v    <= sv_q ^ sw_q;
    ctrl4_q.ovf_u    <= nu >= dfull;
    ctrl4_q.ovf_v    <= nv >= dfull;
    ctrl4_q.valid    <= 1'b0;
    den4_q  <= mw_q;
    remu4_q <= nu;
    remv4_q <= nv;
  end

  always_comb begin
    ctrl4       = ctrl4_q;
    ctrl4.valid = v4_q;
  end
  assign ctrl_c[0] = ctrl4;
  assign den_c[0]  = den4_q;
  assign remu_c[0] = remu4_q;
  assign remv_c[0] = remv4_q;
  assign qu_c[0]   = '0;
  assign qv_c[0]   = '0;

  for (genvar k = 0; k < CB; k++) begin : g_cell
    pwa_div_cell #(
      .CB    (CB),
      .SW    (SW),
      .RW    (RW),
      .SHIFT (CB - 1 - k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl_c[k]),
      .den_i   (den_c[k]),
      .rem_u_i (remu_c[k]),
      .rem_v_i (remv_c[k]),
      .q_u_i   (qu_c[k]),
      .q_v_i   (qv_c[k]),
      .ctrl_o  (ctrl_c[k+1]),
      .den_o   (den_c[k+1]),
      .rem_u_o (remu_c[k+1]),
      .rem_v_o (remv_c[k+1]),
      .q_u_o   (qu_c[k+1]),
      .q_v_o   (qv_c[k+1])
    );
  end

  // output stage
  pwa_pkg::ctrl_t ce;
  logic [CB-1:0]  qu, qv;
  logic           in_u, in_v, in_img;
  logic           done_q, inside_q;
  logic [CB-1:0]  row_q, col_q;

  assign ce     = ctrl_c[CB];
  assign qu     = qu_c[CB];
  assign qv     = qv_c[CB];
  assign in_u   = ~ce.ovf_u & ~(ce.neg_u & (qu != '0)) & (qu < src_rows);
  assign in_v   = ~ce.ovf_v & ~(ce.neg_v & (qv != '0)) & (qv < src_cols);
  assign in_img = ~ce.den_zero & in_u & in_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ce.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    inside_q <= in_img;
    row_q    <= in_img ? qu : '0;
    col_q    <= in_img ? qv : '0;
  end

  assign done_o       = done_q;
  assign inside_res_o = inside_q;
  assign src_row_o    = row_q;
  assign src_col_o    = col_q;

`ifndef SYNTH
  a_black_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !inside_res_o |-> src_row_o == '0 && src_col_o == '0)
    else $error("black pixel with nonzero address");

  a_row_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && inside_res_o |-> src_row_o < src_rows && src_col_o < src_cols)
    else $error("inside pixel beyond source bounds");

  a_zero_den : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ce.valid && ce.den_zero |=> done_o && !inside_res_o)
    else $error("zero denominator gave an inside pixel");
`endif

endmodule

`default_nettype wire
